[design/bytemap_first_fit_allocator_core_macros.svh]
// assertion macros used by the allocator controller
`ifndef BYTEMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define BYTEMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BFFA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define BFFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BFFA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BFFA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/bffa_pkg.sv]
// types, codes and widths shared by the allocator modules
package bffa_pkg;

   localparam int DEF_MAP_ENTRIES = 1024;
   localparam int END_W     = 11;
   localparam int START_W   = 10;
   localparam int LEN_W     = 11;
   localparam int POS_W     = 10;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_INODE_END = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_INODE_END = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_END        = 2'd2;

   // request kinds
   localparam logic REQ_FIND = 1'b0;
   localparam logic REQ_SET  = 1'b1;

   // map selectors
   localparam logic [1:0] MAP_LARGE = 2'd0;
   localparam logic [1:0] MAP_SMALL = 2'd1;
   localparam logic [1:0] MAP_DATA  = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_HOLDS   = 2'd2,
      STATUS_NOSPACE = 2'd3
   } status_type;

   typedef struct packed {
      logic               req_type;
      logic [1:0]         map_sel;
      logic [START_W-1:0] start_entry;
      logic [LEN_W-1:0]   run_length;
      logic               new_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] position;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic write;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic done;
      logic need_write;
      logic write_done;
   } sts_type;

endpackage

[design/bffa_datapath.sv]
// allocator datapath: range registers, mark stores, scan pipeline, result registers
module bffa_datapath #(
   parameter int MAP_ENTRIES = bffa_pkg::DEF_MAP_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bffa_pkg::cmd_type                 cmd,
   output bffa_pkg::sts_type                 sts,
   input  bffa_pkg::req_payload_type         req_payload,
   input  logic                              csr_we,
   input  logic [bffa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bffa_pkg::END_W-1:0]        csr_wdata,
   output bffa_pkg::rsp_payload_type         rsp_payload
);

   localparam int IDX_W = $clog2(MAP_ENTRIES);
   localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > bffa_pkg::END_W) ? CNT_W : bffa_pkg::END_W;
   localparam int SUM_W = CMP_W + 1;
   localparam logic [CMP_W-1:0] ENTRIES = CMP_W'(MAP_ENTRIES);
   localparam logic [CMP_W-1:0] LAST    = CMP_W'(MAP_ENTRIES - 1);

   logic [bffa_pkg::END_W-1:0] large_end_ff, large_end_in;
   logic [bffa_pkg::END_W-1:0] small_end_ff, small_end_in;
   logic [bffa_pkg::END_W-1:0] data_end_ff, data_end_in;

   bffa_pkg::req_payload_type req_ff;
   logic [CMP_W-1:0]           lo_ff, hi_ff, lo_in, hi_in;
   logic [SUM_W-1:0]           end_ff;
   logic [CMP_W-1:0]           addr_ff, addr_in;
   logic [CMP_W-1:0]           paddr_ff;
   logic                       pv_ff, pv_in;
   logic [bffa_pkg::LEN_W-1:0] run_ff, run_in, run_next;
   logic [CMP_W-1:0]           first_ff, first_in;
   bffa_pkg::status_type       res_status_ff, chk_status;
   logic [CMP_W-1:0]           res_pos_ff, chk_pos;
   bffa_pkg::rsp_payload_type  rsp_ff;

   logic [CMP_W-1:0] le, se, de;
   logic             is_set, step, chk_done, rd_bit;
   logic             inode_rd_ff, data_rd_ff;
   logic             inode_we, data_we, wbit;
   logic [IDX_W-1:0] mem_idx;
   logic             inode_mem [MAP_ENTRIES];
   logic             data_mem [MAP_ENTRIES];

   function automatic logic [CMP_W-1:0] clamp_end(input logic [bffa_pkg::END_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      return (w > ENTRIES) ? ENTRIES : w;
   endfunction

   // config registers
   always_comb begin
      large_end_in = large_end_ff;
      small_end_in = small_end_ff;
      data_end_in  = data_end_ff;
      if (csr_we) begin
         case (csr_index)
            bffa_pkg::CSR_LARGE_INODE_END: large_end_in = csr_wdata;
            bffa_pkg::CSR_SMALL_INODE_END: small_end_in = csr_wdata;
            bffa_pkg::CSR_DATA_END:        data_end_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         large_end_ff <= '0;
         small_end_ff <= '0;
         data_end_ff  <= '0;
      end else begin
         large_end_ff <= large_end_in;
         small_end_ff <= small_end_in;
         data_end_ff  <= data_end_in;
      end
   end

   // range of the selected map
   always_comb begin
      le    = clamp_end(large_end_ff);
      se    = clamp_end(small_end_ff);
      de    = clamp_end(data_end_ff);
      lo_in = '0;
      hi_in = '0;
      case (req_payload.map_sel)
         bffa_pkg::MAP_LARGE: hi_in = le;
         bffa_pkg::MAP_SMALL: begin
            lo_in = le;
            hi_in = (se < le) ? le : se;
         end
         bffa_pkg::MAP_DATA:  hi_in = de;
         default: ;
      endcase
   end

   // check stage on the registered read data
   assign is_set   = (req_ff.req_type == bffa_pkg::REQ_SET);
   assign step     = cmd.scan & pv_ff;
   assign rd_bit   = (req_ff.map_sel == bffa_pkg::MAP_DATA) ? data_rd_ff : inode_rd_ff;
   assign run_next = run_ff + bffa_pkg::LEN_W'(1);

   always_comb begin
      chk_done   = 1'b0;
      chk_status = bffa_pkg::STATUS_NOSPACE;
      chk_pos    = '0;
      run_in     = run_ff;
      first_in   = first_ff;
      if (is_set) begin
         if (paddr_ff < lo_ff || paddr_ff >= hi_ff) begin
            chk_done   = 1'b1;
            chk_status = bffa_pkg::STATUS_RANGE;
         end else if (req_ff.run_length == '0) begin
            chk_done   = 1'b1;
            chk_status = bffa_pkg::STATUS_OK;
            chk_pos    = CMP_W'(req_ff.start_entry);
         end else if (rd_bit == req_ff.new_value) begin
            chk_done   = 1'b1;
            chk_status = bffa_pkg::STATUS_HOLDS;
         end else if (SUM_W'(paddr_ff) + SUM_W'(1) == end_ff) begin
            chk_done   = 1'b1;
            chk_status = bffa_pkg::STATUS_OK;
            chk_pos    = CMP_W'(req_ff.start_entry);
         end
      end else begin
         if (req_ff.run_length == '0 || paddr_ff >= hi_ff) begin
            chk_done = 1'b1;
         end else if (!rd_bit) begin
            if (run_ff == '0) first_in = paddr_ff;
            if (run_next == req_ff.run_length) begin
               chk_done   = 1'b1;
               chk_status = bffa_pkg::STATUS_OK;
               chk_pos    = (run_ff == '0) ? paddr_ff : first_ff;
            end else begin
               run_in = run_next;
            end
         end else begin
            run_in = '0;
         end
      end
   end

   assign sts.done       = step & chk_done;
   assign sts.need_write = is_set & (chk_status == bffa_pkg::STATUS_OK) &
                           (req_ff.run_length != '0);
   assign sts.clear_done = (addr_ff == LAST);
   assign sts.write_done = (SUM_W'(addr_ff) + SUM_W'(1) == end_ff);

   // address counter shared by clear, scan and write
   always_comb begin
      addr_in = addr_ff;
      if (cmd.load) begin
         addr_in = (req_payload.req_type == bffa_pkg::REQ_SET) ?
                   CMP_W'(req_payload.start_entry) : lo_in;
      end else if (step && chk_done) begin
         addr_in = CMP_W'(req_ff.start_entry);
      end else if (cmd.scan || cmd.write || cmd.clear) begin
         addr_in = addr_ff + CMP_W'(1);
      end
   end

   assign pv_in = cmd.scan & ~(step & chk_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         pv_ff   <= 1'b0;
      end else begin
         addr_ff <= addr_in;
         pv_ff   <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      paddr_ff <= addr_ff;
      if (cmd.load) begin
         req_ff <= req_payload;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         end_ff <= SUM_W'(req_payload.start_entry) + SUM_W'(req_payload.run_length);
         run_ff <= '0;
      end else if (step) begin
         run_ff   <= run_in;
         first_ff <= first_in;
         if (chk_done) begin
            res_status_ff <= chk_status;
            res_pos_ff    <= chk_pos;
         end
      end
      if (cmd.out_load) begin
         rsp_ff.status   <= res_status_ff;
         rsp_ff.position <= res_pos_ff[bffa_pkg::POS_W-1:0];
      end
   end

   assign rsp_payload = rsp_ff;

   // mark stores
   assign mem_idx  = addr_ff[IDX_W-1:0];
   assign wbit     = cmd.clear ? 1'b0 : req_ff.new_value;
   assign inode_we = cmd.clear | (cmd.write & (req_ff.map_sel != bffa_pkg::MAP_DATA));
   assign data_we  = cmd.clear | (cmd.write & (req_ff.map_sel == bffa_pkg::MAP_DATA));

   always_ff @(posedge clock) begin
      if (inode_we) inode_mem[mem_idx] <= wbit;
      inode_rd_ff <= inode_mem[mem_idx];
   end

   always_ff @(posedge clock) begin
      if (data_we) data_mem[mem_idx] <= wbit;
      data_rd_ff <= data_mem[mem_idx];
   end

endmodule

[design/bffa_controller.sv]
// allocator controller: sequencing of clear, scan, write and result transfer
`include "bytemap_first_fit_allocator_core_macros.svh"

module bffa_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bffa_pkg::cmd_type cmd,
   input  bffa_pkg::sts_type sts
);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_WRITE  = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.done) state_in = sts.need_write ? S_WRITE : S_RESULT;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            if (sts.write_done) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `BFFA_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_valid && req_ready, state_ff == S_SCAN)
   `BFFA_ASSERT_IMP(a_load_slot_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready)
   `BFFA_ASSERT_NEXT(a_write_follows_scan, clock, reset, state_ff == S_SCAN && sts.done && sts.need_write, state_ff == S_WRITE)
   `BFFA_ASSERT_NEXT(a_result_presented, clock, reset, cmd.out_load, rsp_valid)

endmodule

[design/bytemap_first_fit_allocator_core.sv]
// top level of the first-fit bytemap allocator
// First-fit allocator over three one-bit maps: the large and small inode maps share
// one store split at large_inode_end, the data map has its own store. A find transfer
// returns the first entry of the first run of run_length free marks in the selected
// range (or no space); a set transfer writes new_value over a run, all or nothing,
// reporting out of range or already holds value at the first offending entry. One
// request is handled at a time, one map entry per clock through a registered memory
// read; a set checks its whole run before it writes it. The output register lets the
// next request start while a result waits. After reset both stores are cleared one
// entry a cycle, during which req_ready stays low; csr writes are taken at any time
// but belong in idle periods.
module bytemap_first_fit_allocator_core #(
   parameter int MAP_ENTRIES = bffa_pkg::DEF_MAP_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bffa_pkg::req_payload_type      req_payload,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bffa_pkg::rsp_payload_type      rsp_payload,
   // register write port
   input  logic                           csr_we,
   input  logic [bffa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bffa_pkg::END_W-1:0]     csr_wdata
);

   // command and status between the two halves
   bffa_pkg::cmd_type cmd;
   bffa_pkg::sts_type sts;

   // sequencer: clear pass, scan, write pass, result transfer
   bffa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // stores, range registers and the per-entry check
   bffa_datapath #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule
